// ===== src/lfa_pkg.sv =====
// lfa_pkg: shared constants, payload types and control structs of the line frame averager
// no dependencies; imported by every module of the block except lfa_ram
`default_nettype none

package lfa_pkg;

   // geometry and arithmetic sizing
   localparam int PIXELS      = 512;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_COUNT   = 1024;
   localparam int POS_W       = $clog2(PIXELS);
   localparam int CNT_W       = 11;
   localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_COUNT);
   localparam int DIV_CNT_W   = $clog2(SUM_W);

   localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(10);

   typedef struct packed {
      logic [15:0] sample;
      logic        use_frame;
   } req_type;

   typedef struct packed {
      logic [15:0] average;
      logic [8:0]  pixel_index;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic add;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic divide;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== src/lfa_ram.sv =====
// lfa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/lfa_ctrl.sv =====
// lfa_ctrl: sequencing state machine of the line frame averager
// depends on lfa_pkg for the command and status structs
`default_nettype none

module lfa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire lfa_pkg::status_type status,
   output lfa_pkg::cmd_type        cmd
);
   import lfa_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ADD   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = status.divide ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/lfa_datapath.sv =====
// lfa_datapath: pixel counters, sum memory, serial divider and output register
// depends on lfa_pkg and lfa_ram
`default_nettype none

module lfa_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lfa_pkg::cmd_type         cmd,
   output lfa_pkg::status_type           status,
   input  wire lfa_pkg::req_type         req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output lfa_pkg::rsp_type              rsp_data,
   input  wire logic                     csr_write,
   input  wire logic [lfa_pkg::CNT_W-1:0] csr_data
);
   import lfa_pkg::*;

   // control registers
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     frames_ff, frames_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [POS_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // per-item registers
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic                   use_ff, use_in;
   logic                   last_ff, last_in;
   logic                   close_ff, close_in;
   logic [POS_W-1:0]       idx_ff, idx_in;

   // divider
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   rsp_type              out_ff, out_in;

   logic [CNT_W-1:0]     eff_n;
   logic                 is_last;
   logic                 closing;
   logic [SUM_W-1:0]     rd_sum;
   logic [SUM_W-1:0]     sum;
   logic                 ram_wr_en;
   logic [POS_W-1:0]     ram_wr_addr;
   logic [SUM_W-1:0]     ram_wr_data;
   logic [CNT_W:0]       shifted;
   logic                 ge;
   logic [CNT_W:0]       diff;

   // zero acts as one, above the maximum clamps to it
   always_comb begin
      if (count_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_COUNT)) begin
         eff_n = CNT_W'(MAX_COUNT);
      end else begin
         eff_n = count_ff;
      end
   end

   assign is_last = (pos_ff == POS_W'(PIXELS - 1));
   assign closing = ((CNT_W+1)'(frames_ff) + (CNT_W+1)'(1)) >= (CNT_W+1)'(eff_n);

   lfa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (PIXELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (pos_ff),
      .rd_data (rd_sum)
   );

   assign sum         = rd_sum + SUM_W'(smp_ff);
   assign ram_wr_en   = cmd.clear_step | (cmd.add & use_ff);
   assign ram_wr_addr = cmd.clear_step ? clr_cnt_ff : idx_ff;
   assign ram_wr_data = (cmd.clear_step | close_ff) ? '0 : sum;

   // one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - (CNT_W+1)'(eff_n);
   assign ge      = (shifted >= (CNT_W+1)'(eff_n));

   always_comb begin
      pos_in       = pos_ff;
      frames_in    = frames_ff;
      count_in     = count_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      smp_in       = smp_ff;
      use_in       = use_ff;
      last_in      = last_ff;
      close_in     = close_ff;
      idx_in       = idx_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      out_in       = out_ff;

      if (csr_write) begin
         count_in = csr_data;
      end

      if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + POS_W'(1);
      end

      if (cmd.accept) begin
         smp_in   = SAMPLE_BITS'(req_data.sample);
         use_in   = req_data.use_frame;
         last_in  = is_last;
         close_in = closing;
         idx_in   = pos_ff;
         pos_in   = is_last ? '0 : pos_ff + POS_W'(1);
         if (is_last && req_data.use_frame) begin
            frames_in = closing ? '0 : frames_ff + CNT_W'(1);
         end
      end

      if (cmd.add) begin
         quo_in     = sum;
         rem_in     = '0;
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         quo_in     = {quo_ff[SUM_W-2:0], ge};
         rem_in     = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in       = 1'b1;
         out_in.average     = 16'(quo_ff);
         out_in.pixel_index = 9'(idx_ff);
         out_in.last        = last_ff;
      end
   end

   assign status.clear_last = (clr_cnt_ff == POS_W'(PIXELS - 1));
   assign status.divide     = use_ff & close_ff;
   assign status.div_last   = (div_cnt_ff == DIV_CNT_W'(SUM_W - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frames_ff    <= '0;
         count_ff     <= RESET_COUNT;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         frames_ff    <= frames_in;
         count_ff     <= count_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff     <= smp_in;
      use_ff     <= use_in;
      last_ff    <= last_in;
      close_ff   <= close_in;
      idx_ff     <= idx_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      out_ff     <= out_in;
   end

endmodule

`default_nettype wire

// ===== src/line_frame_averager_unit.sv =====
// line_frame_averager_unit: top level of the per-pixel line frame averager
// depends on lfa_pkg, lfa_ctrl, lfa_datapath (which holds lfa_ram)
//
// usage
//   req channel: one pixel sample per item, pixels in line order, a line is
//     PIXELS items; use_frame marks samples that count toward the average
//   rsp channel: one item per used pixel of the line that closes a group of
//     average_count used lines; carries sum / count (truncated), the pixel
//     index and a last flag on the final pixel of the line
//   csr channel: write-only average_count register (reset 10); zero acts as
//     one, values above 1024 act as 1024; always ready
// timing
//   an item that gives no result passes through the sum memory read, then
//   the write back; an item that gives a result goes through read, add,
//   the bit-serial divider (one quotient bit per cycle) and then
//   the load into the output register
//   the result register sits between divider and rsp port, so the next
//   item is taken while a result waits; a result-making item waits in the
//   hold state only while the previous result is still stalled
// reset
//   synchronous; afterwards req_stall stays high while the sum memory is
//   swept to zero, one entry per cycle
`default_nettype none

module line_frame_averager_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // pixel samples in
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire lfa_pkg::req_type          req_data,
   // averaged pixels out
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output lfa_pkg::rsp_type               rsp_data,
   // average_count register write
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [lfa_pkg::CNT_W-1:0] csr_data
);
   import lfa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // the register can take a write in any cycle
   assign csr_ready = 1'b1;

   // sequencing: clear sweep, accept, add, divide, result hand-off
   lfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // counters, sum memory, divider and output register
   lfa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire

// ===== src/lfa_checker.sv =====
// lfa_checker: port-level assertions for line_frame_averager_unit
// depends on lfa_pkg; attached to the top level by the bind below
`default_nettype none

module lfa_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire lfa_pkg::req_type          req_data,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire lfa_pkg::rsp_type          rsp_data,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic [lfa_pkg::CNT_W-1:0] csr_data
);
   import lfa_pkg::*;

   // memory clear sweep holds off input right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not stalled after reset");

   // one item at a time: the cycle after an accept is always stalled
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted back to back");

   // no result can appear the cycle right after an accept
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind line_frame_averager_unit lfa_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for line_frame_averager_unit, with a predictor for the
// per-pixel sums, directed line tests and random line traffic; depends on lfa_pkg

module tb_top;
   import lfa_pkg::*;

   localparam int SETTLE_CYCLES  = 40;    // longer than one result-making item
   localparam int WATCHDOG_LIMIT = 4000;  // covers the sweep after reset and slow results
   localparam int RANDOM_ITEMS   = 190;   // random bursts, all inside the second line

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CNT_W-1:0] csr_data = '0;

   line_frame_averager_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state, same reset values as the block
   longint unsigned  pixel_total [PIXELS] = '{default: 0};
   int unsigned      line_pos = 0;
   int unsigned      lines_done = 0;
   logic [CNT_W-1:0] group_reg = RESET_COUNT;
   rsp_type          pending_averages [$];

   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   // one accepted pixel: if used, update its sum and queue the average if the group closes
   function automatic void predict_pixel(input req_type item);
      longint unsigned total;
      int unsigned     n;
      logic            at_end;
      logic            closing;
      rsp_type         avg;
      n = (group_reg == 0) ? 1 : ((group_reg > MAX_COUNT) ? MAX_COUNT : group_reg);
      at_end = (line_pos == PIXELS - 1);
      closing = (lines_done + 1 >= n);
      if (item.use_frame) begin
         total = pixel_total[line_pos] + item.sample;
         if (closing) begin
            avg.average = 16'(total / n);
            avg.pixel_index = 9'(line_pos);
            avg.last = at_end;
            pending_averages.push_back(avg);
            pixel_total[line_pos] = 0;
         end else begin
            pixel_total[line_pos] = total;
         end
         // a line counts as used by the flag of its final pixel
         if (at_end) lines_done = closing ? 0 : ((lines_done + 1) & 'h7FF);
      end
      line_pos = at_end ? 0 : line_pos + 1;
   endfunction

   task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
      send_idle_pct = sender_pct;
      recv_stall_pct = receiver_pct;
   endtask

   // entered right after an acceptance edge, so one assignment per falling edge
   task automatic send_pixel(input logic [15:0] value, input logic use_it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= '{sample: value, use_frame: use_it};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(req_data);
   endtask

   task automatic hold_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_averages.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // pinned lines put full scale on pixel 0, zero on pixel 1, and use pixels 0, 1 and the final pixel
   task automatic send_pixels(input int unsigned count, input int unsigned use_pct,
                              input bit pinned);
      logic [15:0] value;
      logic        use_it;
      repeat (count) begin
         value = 16'($urandom);
         use_it = ($urandom_range(99) < use_pct);
         if (pinned) begin
            if (line_pos == 0) value = 16'hFFFF;
            if (line_pos == 1) value = 16'h0000;
            if (line_pos < 2 || line_pos == PIXELS - 1) use_it = 1'b1;
         end
         send_pixel(value, use_it);
      end
   endtask

   task automatic write_average_count(input logic [CNT_W-1:0] value);
      hold_sender();
      wait_drained();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      group_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // reset count of ten: the start of the first line only sums, nothing comes out
   task automatic test_reset_count();
      send_pixels(150, 95, 1'b1);
   endtask

   // clamp above the range and top of it, then a count of two that the used
   // final pixel of the first line leaves one line short of
   task automatic test_count_limits();
      write_average_count('1);
      send_pixels(100, 95, 1'b1);
      write_average_count(CNT_W'(MAX_COUNT));
      send_pixels(100, 95, 1'b1);
      write_average_count(CNT_W'(2));
      send_pixels(PIXELS - line_pos, 95, 1'b1);
   endtask

   // zero acts as one and sits below the line already summed: every used pixel
   // comes back, pixel 0 wraps its doubled full-scale sum
   task automatic test_count_zero();
      write_average_count('0);
      send_pixels(200, 90, 1'b1);
   endtask

   // short bursts with the count changed between them, sparse use now and then
   task automatic test_random_counts();
      int unsigned      sent;
      int unsigned      burst;
      int unsigned      use_pct;
      logic [CNT_W-1:0] n;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS / 2) set_idling(0, 0);
         case ($urandom_range(9))
            0: n = '0;
            1: n = '1;
            default: n = CNT_W'($urandom_range(1, 4));
         endcase
         write_average_count(n);
         use_pct = ($urandom_range(3) == 0) ? $urandom_range(0, 100) : 100;
         burst = $urandom_range(1, 40);
         if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
         send_pixels(burst, use_pct, 1'b0);
         sent += burst;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            $display("%0t unexpected result: expected none, actual average %h pixel %0d last %b",
                     $time, rsp_data.average, rsp_data.pixel_index, rsp_data.last);
            mismatch_count++;
         end else begin
            want = pending_averages.pop_front();
            if (rsp_data.average !== want.average) begin
               $display("%0t pixel %0d average: expected %h, actual %h", $time,
                        want.pixel_index, want.average, rsp_data.average);
               mismatch_count++;
            end
            if (rsp_data.pixel_index !== want.pixel_index) begin
               $display("%0t pixel_index: expected %0d, actual %0d", $time,
                        want.pixel_index, rsp_data.pixel_index);
               mismatch_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t pixel %0d last: expected %b, actual %b", $time,
                        want.pixel_index, want.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

   // no item on any channel for too long means the block hung
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      set_idling(33, 63);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_count();
      test_count_limits();
      test_count_zero();
      set_idling(63, 33);
      test_random_counts();
      hold_sender();
      wait_drained();
      if (mismatch_count == 0 && pending_averages.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
